>>> design/urs_pkg.sv
package urs_pkg;

  // Field widths
  localparam int unsigned DIST_W  = 11;
  localparam int unsigned TEMP_W  = 9;
  localparam int unsigned ADC_W   = 12;
  localparam int unsigned TICK_W  = 20;
  localparam int unsigned TOUT_W  = 16;
  localparam int unsigned TRIG_W  = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  // Largest values the readings can take
  localparam int unsigned DIST_MAX = 1123;
  localparam int unsigned TEMP_MAX = 330;

  // Echo time to centimetres: 343 / 20000 per tick, stepped as a remainder
  localparam int unsigned ECHO_STEP = 343;
  localparam int unsigned ECHO_DIV  = 20000;
  localparam int unsigned FRAC_W    = 15;

  // floor(adc * 330 / 4095) as (adc * TEMP_MUL) >> TEMP_SHIFT, exact for 12-bit adc
  localparam int unsigned TEMP_SHIFT = 25;
  localparam int unsigned TEMP_MUL_W = 22;
  localparam logic [TEMP_MUL_W-1:0] TEMP_MUL = 22'd2704021;

  typedef enum logic [1:0] {
    MODE_TICK = 2'd0,
    MODE_TEMP = 2'd1,
    MODE_GAS  = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STOP_DISTANCE = 3'd0,
    CFG_TEMP_LIMIT    = 3'd1,
    CFG_GAS_LIMIT     = 3'd2,
    CFG_ECHO_TIMEOUT  = 3'd3,
    CFG_TRIGGER_WIDTH = 3'd4,
    CFG_SAMPLE_GAP    = 3'd5,
    CFG_ROUND_REST    = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_LEAD = 3'd0,
    PH_HIGH = 3'd1,
    PH_RISE = 3'd2,
    PH_FALL = 3'd3,
    PH_GAP  = 3'd4,
    PH_REST = 3'd5
  } phase_e;

  typedef struct packed {
    logic [1:0]       mode;
    logic             echo_level;
    logic [ADC_W-1:0] adc_sample;
  } in_item_t;

  typedef struct packed {
    logic              trigger_level;
    logic              drive_en;
    logic [DIST_W-1:0] range_avg;
    logic [TEMP_W-1:0] temp_deg;
    logic [ADC_W-1:0]  gas_level;
  } out_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] stop_distance;
    logic [TEMP_W-1:0] temp_limit;
    logic [ADC_W-1:0]  gas_limit;
    logic [TOUT_W-1:0] echo_timeout;
    logic [TRIG_W-1:0] trigger_width;
    logic [TICK_W-1:0] sample_gap;
    logic [TICK_W-1:0] round_rest;
  } urs_cfg_t;

  typedef struct packed {
    logic              trigger_level;
    logic [DIST_W-1:0] distance;
  } rng_status_t;

  localparam urs_cfg_t CFG_RESET = '{
    stop_distance: 11'd20,
    temp_limit:    9'd38,
    gas_limit:     12'd1600,
    echo_timeout:  16'd30000,
    trigger_width: 8'd10,
    sample_gap:    20'd30000,
    round_rest:    20'd250000
  };

endpackage

>>> design/ultrasonic_range_safety_interlock_top.sv
// An input transfer updates the state and marks it pending; the output register
// takes the result once empty or being read. Throughput: one item per cycle while
// the output is not stalled, as a finished result waits while the next is taken.
// Reset: the sequencer starts in the trigger low lead-in with all counts, the
// averaged distance and the sensor readings at zero; registers take their defaults.
module ultrasonic_range_safety_interlock_top import urs_pkg::*; #(
  parameter int unsigned SAMPLES_PER_ROUND = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  urs_cfg_t          cfg_q;
  logic [TEMP_W-1:0] temp_q;
  logic [ADC_W-1:0]  gas_q;
  logic              pend_q;
  logic              out_valid_q;
  out_item_t         out_item_q, out_item_d;

  logic              in_xfer, tick_en, load_ok, load;
  logic [ADC_W+TEMP_MUL_W-1:0] temp_prod;
  rng_status_t       status;

  // Handshake: pend_q marks state that has been updated but not yet reported
  assign load_ok     = !out_valid_q || out_ready_i;
  assign load        = pend_q && load_ok;
  assign in_ready_o  = !pend_q || load_ok;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign tick_en     = in_xfer && (mode_e'(in_item_i.mode) == MODE_TICK);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_STOP_DISTANCE: cfg_q.stop_distance <= cfg_data_i[DIST_W-1:0];
        CFG_TEMP_LIMIT:    cfg_q.temp_limit    <= cfg_data_i[TEMP_W-1:0];
        CFG_GAS_LIMIT:     cfg_q.gas_limit     <= cfg_data_i[ADC_W-1:0];
        CFG_ECHO_TIMEOUT:  cfg_q.echo_timeout  <= cfg_data_i[TOUT_W-1:0];
        CFG_TRIGGER_WIDTH: cfg_q.trigger_width <= cfg_data_i[TRIG_W-1:0];
        CFG_SAMPLE_GAP:    cfg_q.sample_gap    <= cfg_data_i[TICK_W-1:0];
        CFG_ROUND_REST:    cfg_q.round_rest    <= cfg_data_i[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Ranging sequencer
  urs_ranger #(
    .SAMPLES_PER_ROUND(SAMPLES_PER_ROUND)
  ) u_ranger (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tick_i  (tick_en),
    .echo_i  (in_item_i.echo_level),
    .cfg_i   (cfg_q),
    .status_o(status)
  );

  // Scale the temperature sample by reciprocal
  assign temp_prod = (ADC_W + TEMP_MUL_W)'(in_item_i.adc_sample) *
                     (ADC_W + TEMP_MUL_W)'(TEMP_MUL);

  // Latch sensor readings
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q <= '0;
      gas_q  <= '0;
    end else if (in_xfer) begin
      case (mode_e'(in_item_i.mode))
        MODE_TEMP: temp_q <= temp_prod[TEMP_SHIFT +: TEMP_W];
        MODE_GAS:  gas_q  <= in_item_i.adc_sample;
        default: ;
      endcase
    end
  end

  // Form the result from the updated state
  always_comb begin
    out_item_d.trigger_level = status.trigger_level;
    out_item_d.drive_en      = (status.distance > cfg_q.stop_distance) &&
                               (temp_q < cfg_q.temp_limit) &&
                               (gas_q < cfg_q.gas_limit);
    out_item_d.range_avg     = status.distance;
    out_item_d.temp_deg      = temp_q;
    out_item_d.gas_level     = gas_q;
  end

  // Advance pending marker and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) pend_q <= 1'b1;
      else if (load) pend_q <= 1'b0;
      if (load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) out_item_q <= out_item_d;
  end

  // A stalled output with a pending result must block new transfers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while pending result is blocked");

  // Every transfer leaves a pending result behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> pend_q)
    else $error("transfer lost its result");

  // Scaled readings stay in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    temp_q <= TEMP_W'(TEMP_MAX))
    else $error("temperature out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.distance <= DIST_W'(DIST_MAX))
    else $error("averaged distance out of range");

endmodule

>>> design/urs_ranger.sv
module urs_ranger import urs_pkg::*; #(
  parameter int unsigned SAMPLES_PER_ROUND = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        tick_i,
  input  logic        echo_i,
  input  urs_cfg_t    cfg_i,
  output rng_status_t status_o
);

  localparam int unsigned IDX_W = $clog2(SAMPLES_PER_ROUND + 1);
  localparam int unsigned SUM_W = $clog2(SAMPLES_PER_ROUND * DIST_MAX + 1);
  // Average by reciprocal: exact while sum * SAMPLES_PER_ROUND <= 2**AVG_S
  localparam int unsigned AVG_S = SUM_W + IDX_W;
  localparam int unsigned PROD_W = SUM_W + AVG_S + 1;
  localparam logic [AVG_S:0] AVG_MUL =
    (AVG_S + 1)'(((64'd1 << AVG_S) + 64'(SAMPLES_PER_ROUND) - 64'd1) /
                 64'(SAMPLES_PER_ROUND));

  phase_e              phase_q, phase_d;
  logic [TICK_W-1:0]   tick_q, tick_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [DIST_W-1:0]   avg_q, avg_d;
  logic [FRAC_W-1:0]   frac_q, frac_d;
  logic [DIST_W-1:0]   cm_q, cm_d;

  logic [TICK_W:0]     tick_inc;
  logic                width_done, wait_over, gap_done, rest_done, round_full;
  logic [FRAC_W:0]     frac_sum;
  logic [PROD_W-1:0]   avg_prod;
  logic [DIST_W-1:0]   avg_val;

  // Phase compares against the incremented count
  assign tick_inc   = {1'b0, tick_q} + (TICK_W + 1)'(1);
  assign width_done = tick_inc >= (TICK_W + 1)'(cfg_i.trigger_width);
  assign wait_over  = tick_inc >  (TICK_W + 1)'(cfg_i.echo_timeout);
  assign gap_done   = tick_inc >= {1'b0, cfg_i.sample_gap};
  assign rest_done  = tick_inc >= {1'b0, cfg_i.round_rest};
  assign round_full = idx_q >= IDX_W'(SAMPLES_PER_ROUND);

  // Running echo length in cm: add the step, carry one cm per wrap of the divisor
  assign frac_sum = {1'b0, frac_q} + (FRAC_W + 1)'(ECHO_STEP);

  // Round average from the stored sum
  assign avg_prod = PROD_W'(sum_q) * PROD_W'(AVG_MUL);
  assign avg_val  = avg_prod[AVG_S +: DIST_W];

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (tick_i) begin
      case (phase_q)
        PH_LEAD: if (width_done) phase_d = PH_HIGH;
        PH_HIGH: if (width_done) phase_d = PH_RISE;
        PH_RISE: begin
          if (echo_i) phase_d = PH_FALL;
          else if (wait_over) phase_d = PH_GAP;
        end
        PH_FALL: if (!echo_i || wait_over) phase_d = PH_GAP;
        PH_GAP: begin
          if (gap_done) phase_d = round_full ? PH_REST : PH_LEAD;
        end
        PH_REST: if (rest_done) phase_d = PH_LEAD;
        default: phase_d = PH_LEAD;
      endcase
    end
  end

  // Phase outputs
  always_comb begin
    status_o.trigger_level = (phase_q == PH_HIGH);
    status_o.distance      = avg_q;
  end

  // Counters, echo timing and round accumulation
  always_comb begin
    tick_d = tick_q;
    idx_d  = idx_q;
    sum_d  = sum_q;
    avg_d  = avg_q;
    frac_d = frac_q;
    cm_d   = cm_q;
    if (tick_i) begin
      case (phase_q)
        PH_LEAD, PH_HIGH: begin
          tick_d = width_done ? '0 : tick_inc[TICK_W-1:0];
        end
        PH_RISE: begin
          if (echo_i) begin
            tick_d = '0;
            frac_d = '0;
            cm_d   = '0;
          end else if (wait_over) begin
            // no echo edge in time: count a zero measurement
            tick_d = '0;
            idx_d  = idx_q + IDX_W'(1);
          end else begin
            tick_d = tick_inc[TICK_W-1:0];
          end
        end
        PH_FALL: begin
          if (!echo_i) begin
            tick_d = '0;
            idx_d  = idx_q + IDX_W'(1);
            sum_d  = sum_q + SUM_W'(cm_q);
          end else if (wait_over) begin
            tick_d = '0;
            idx_d  = idx_q + IDX_W'(1);
          end else begin
            tick_d = tick_inc[TICK_W-1:0];
            if (frac_sum >= (FRAC_W + 1)'(ECHO_DIV)) begin
              frac_d = FRAC_W'(frac_sum - (FRAC_W + 1)'(ECHO_DIV));
              cm_d   = cm_q + DIST_W'(1);
            end else begin
              frac_d = frac_sum[FRAC_W-1:0];
            end
          end
        end
        PH_GAP: begin
          if (gap_done) begin
            tick_d = '0;
            if (round_full) begin
              avg_d = avg_val;
              sum_d = '0;
              idx_d = '0;
            end
          end else begin
            tick_d = tick_inc[TICK_W-1:0];
          end
        end
        PH_REST: begin
          tick_d = rest_done ? '0 : tick_inc[TICK_W-1:0];
        end
        default: tick_d = '0;
      endcase
    end
  end

  // Hold sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEAD;
      tick_q  <= '0;
      idx_q   <= '0;
      sum_q   <= '0;
      avg_q   <= '0;
      frac_q  <= '0;
      cm_q    <= '0;
    end else begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      idx_q   <= idx_d;
      sum_q   <= sum_d;
      avg_q   <= avg_d;
      frac_q  <= frac_d;
      cm_q    <= cm_d;
    end
  end

endmodule

>>> tb/tb_ultrasonic_range_safety_interlock_top.sv
module tb_ultrasonic_range_safety_interlock_top import urs_pkg::*; ();

  localparam int unsigned ROUND_SAMPLES  = 5;
  localparam int unsigned ADC_FULL_SCALE = 4095;
  localparam int unsigned NUM_SETS       = 5;
  localparam int unsigned STEADY_SET     = 2;
  localparam int unsigned PRESSURE_SET   = 4;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned DRAIN_LIMIT    = 2000;
  localparam int unsigned MAX_CYCLES     = 200000;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned IDLE_PERCENT   = 15;
  // Mode code that the block leaves without effect
  localparam logic [1:0]  MODE_SPARE     = 2'd3;

  // Interlock predictor and store of expected results
  class interlock_scoreboard;
    int unsigned stop_distance, temp_limit, gas_limit, echo_timeout;
    int unsigned trigger_width, sample_gap, round_rest;
    phase_e      phase;
    int unsigned tick_count, measure_index, range_sum;
    int unsigned average_distance, temperature_value, gas_value;
    out_item_t   pending_results[$];
    int unsigned failures, items_taken, results_checked, rounds_done, motor_on_count;

    function new();
      stop_distance     = 32'(CFG_RESET.stop_distance);
      temp_limit        = 32'(CFG_RESET.temp_limit);
      gas_limit         = 32'(CFG_RESET.gas_limit);
      echo_timeout      = 32'(CFG_RESET.echo_timeout);
      trigger_width     = 32'(CFG_RESET.trigger_width);
      sample_gap        = 32'(CFG_RESET.sample_gap);
      round_rest        = 32'(CFG_RESET.round_rest);
      phase             = PH_LEAD;
      tick_count        = 0;
      measure_index     = 0;
      range_sum         = 0;
      average_distance  = 0;
      temperature_value = 0;
      gas_value         = 0;
      failures          = 0;
      items_taken       = 0;
      results_checked   = 0;
      rounds_done       = 0;
      motor_on_count    = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_STOP_DISTANCE: stop_distance = 32'(value[DIST_W-1:0]);
        CFG_TEMP_LIMIT:    temp_limit    = 32'(value[TEMP_W-1:0]);
        CFG_GAS_LIMIT:     gas_limit     = 32'(value[ADC_W-1:0]);
        CFG_ECHO_TIMEOUT:  echo_timeout  = 32'(value[TOUT_W-1:0]);
        CFG_TRIGGER_WIDTH: trigger_width = 32'(value[TRIG_W-1:0]);
        CFG_SAMPLE_GAP:    sample_gap    = 32'(value);
        CFG_ROUND_REST:    round_rest    = 32'(value);
        default: ;
      endcase
    endfunction

    // Convert echo time to centimetres and move on to the gap
    function void close_measurement(int unsigned elapsed);
      range_sum += (elapsed * ECHO_STEP) / ECHO_DIV;
      measure_index++;
      tick_count = 0;
      phase = PH_GAP;
    endfunction

    function void advance_sequencer(logic echo);
      case (phase)
        PH_LEAD: begin
          tick_count++;
          if (tick_count >= trigger_width) begin
            tick_count = 0;
            phase = PH_HIGH;
          end
        end
        PH_HIGH: begin
          tick_count++;
          if (tick_count >= trigger_width) begin
            tick_count = 0;
            phase = PH_RISE;
          end
        end
        PH_RISE: begin
          if (echo) begin
            tick_count = 0;
            phase = PH_FALL;
          end else begin
            tick_count++;
            if (tick_count > echo_timeout) close_measurement(0);
          end
        end
        PH_FALL: begin
          if (!echo) begin
            close_measurement(tick_count);
          end else begin
            tick_count++;
            if (tick_count > echo_timeout) close_measurement(0);
          end
        end
        PH_GAP: begin
          tick_count++;
          if (tick_count >= sample_gap) begin
            tick_count = 0;
            if (measure_index >= ROUND_SAMPLES) begin
              average_distance = (range_sum / ROUND_SAMPLES) & 'h7FF;
              range_sum = 0;
              measure_index = 0;
              rounds_done++;
              phase = PH_REST;
            end else begin
              phase = PH_LEAD;
            end
          end
        end
        PH_REST: begin
          tick_count++;
          if (tick_count >= round_rest) begin
            tick_count = 0;
            phase = PH_LEAD;
          end
        end
        default: begin
          tick_count = 0;
          phase = PH_LEAD;
        end
      endcase
    endfunction

    // Update state for one transfer in and queue the result it causes
    function void take_item(in_item_t it);
      out_item_t   predicted;
      int unsigned adc;
      adc = 32'(it.adc_sample);
      case (it.mode)
        MODE_TICK: advance_sequencer(it.echo_level);
        MODE_TEMP: temperature_value = (adc * TEMP_MAX) / ADC_FULL_SCALE;
        MODE_GAS:  gas_value = adc;
        default: ;
      endcase
      predicted.trigger_level = (phase == PH_HIGH);
      predicted.drive_en      = (average_distance > stop_distance) &&
                                (temperature_value < temp_limit) &&
                                (gas_value < gas_limit);
      predicted.range_avg     = DIST_W'(average_distance);
      predicted.temp_deg      = TEMP_W'(temperature_value);
      predicted.gas_level     = ADC_W'(gas_value);
      if (predicted.drive_en) motor_on_count++;
      pending_results.push_back(predicted);
      items_taken++;
    endfunction

    function void report(string what);
      failures++;
      if (failures <= MAX_REPORTS) $display("ERROR: %s", what);
    endfunction

    function string describe(out_item_t r);
      return $sformatf("trig=%0d run=%0d dist=%0d temp=%0d gas=%0d", r.trigger_level,
                       r.drive_en, r.range_avg, r.temp_deg, r.gas_level);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      results_checked++;
      if (pending_results.size() == 0) begin
        report($sformatf("result %0d arrived with nothing pending: %s", results_checked,
                         describe(got)));
        return;
      end
      want = pending_results.pop_front();
      if (got.trigger_level !== want.trigger_level || got.drive_en !== want.drive_en ||
          got.range_avg !== want.range_avg || got.temp_deg !== want.temp_deg ||
          got.gas_level !== want.gas_level) begin
        report($sformatf("result %0d: expected %s, got %s", results_checked,
                         describe(want), describe(got)));
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  in_item_t              in_item_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_item_t             out_item_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  interlock_scoreboard sb;
  int unsigned         cycle_count = 0;
  bit                  steady = 1'b0;
  bit                  hold_request = 1'b0;
  bit                  hold_taken = 1'b0;
  int unsigned         hold_left = 0;
  int unsigned         rise_delay = 0;
  int unsigned         pulse_len = 0;
  urs_cfg_t            cfg_plan [NUM_SETS];
  int unsigned         set_items [NUM_SETS] = '{350, 120, 350, 150, 200};

  ultrasonic_range_safety_interlock_top #(
    .SAMPLES_PER_ROUND(ROUND_SAMPLES)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Note each input transfer before checking the result transfer of the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.take_item(in_item_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_item_o);
    end
  end

  // Drop the run if it hangs
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= MAX_CYCLES) begin
      $display("ERROR: run stopped after %0d cycles, %0d results still pending", cycle_count,
               sb.pending_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: random stalls, or a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_request && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  function automatic in_item_t item_of(logic [1:0] mode, logic echo, logic [ADC_W-1:0] adc);
    in_item_t it;
    it.mode       = mode;
    it.echo_level = echo;
    it.adc_sample = adc;
    return it;
  endfunction

  // Offer one item from a falling edge and hold it until the transfer
  task automatic send_item(input in_item_t it);
    while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, value);
    @(negedge clk_i);
  endtask

  task automatic load_registers(input urs_cfg_t c);
    write_reg(CFG_STOP_DISTANCE, CFG_DATA_W'(c.stop_distance));
    write_reg(CFG_TEMP_LIMIT,    CFG_DATA_W'(c.temp_limit));
    write_reg(CFG_GAS_LIMIT,     CFG_DATA_W'(c.gas_limit));
    write_reg(CFG_ECHO_TIMEOUT,  CFG_DATA_W'(c.echo_timeout));
    write_reg(CFG_TRIGGER_WIDTH, CFG_DATA_W'(c.trigger_width));
    write_reg(CFG_SAMPLE_GAP,    c.sample_gap);
    write_reg(CFG_ROUND_REST,    c.round_rest);
    cfg_valid_i <= 1'b0;
  endtask

  // Stop offering, wait for outstanding results, then let the pipe settle
  task automatic drain();
    int unsigned waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (sb.pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Mostly well-formed echo pulses shaped by the predicted phase; the rest noise
  task automatic make_item(output in_item_t it);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    it.mode       = MODE_TICK;
    it.echo_level = 1'($urandom_range(0, 1));
    it.adc_sample = ADC_W'($urandom_range(0, ADC_FULL_SCALE));
    // Choose the next pulse shape only outside the echo timing
    if (sb.phase != PH_RISE && sb.phase != PH_FALL) begin
      rise_delay = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 400) : $urandom_range(0, 4);
      pulse_len  = ($urandom_range(0, 9) < 6) ? $urandom_range(59, 180) : $urandom_range(0, 40);
    end
    if (pick < 8) begin
      it.mode = (pick < 4) ? MODE_TEMP : MODE_GAS;
      if ($urandom_range(0, 7) == 0) begin
        it.adc_sample = ($urandom_range(0, 1) != 0) ? ADC_W'(ADC_FULL_SCALE) : '0;
      end
    end else if (pick < 10) begin
      it.mode = MODE_SPARE;
    end else if (pick >= 16) begin
      case (sb.phase)
        PH_RISE: it.echo_level = (sb.tick_count >= rise_delay);
        PH_FALL: it.echo_level = (sb.tick_count < pulse_len);
        default: it.echo_level = 1'b0;
      endcase
    end
  endtask

  initial begin
    in_item_t it;
    sb = new();
    cfg_plan[0] = '{11'd0,    9'd330, 12'd4095, 16'd300,   8'd1,   20'd0,       20'd0};
    cfg_plan[1] = '{11'd1,    9'd38,  12'd1600, 16'd0,     8'd0,   20'd1,       20'd2};
    cfg_plan[2] = '{11'd2,    9'd100, 12'd2000, 16'd150,   8'd2,   20'd3,       20'd10};
    cfg_plan[3] = '{11'd1123, 9'd0,   12'd0,    16'd65535, 8'd255, 20'd1048575, 20'd1048575};
    cfg_plan[4] = '{11'd1,    9'd200, 12'd3000, 16'd120,   8'd1,   20'd0,       20'd0};

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: converter extremes, gas limit edge, spare mode, trigger pulse at defaults
    send_item(item_of(MODE_TEMP, 1'b0, 12'd0));
    send_item(item_of(MODE_TEMP, 1'b1, 12'd4095));
    send_item(item_of(MODE_TEMP, 1'b0, 12'd1241));
    send_item(item_of(MODE_GAS, 1'b0, 12'd0));
    send_item(item_of(MODE_GAS, 1'b1, 12'd4095));
    send_item(item_of(MODE_GAS, 1'b0, 12'd1599));
    send_item(item_of(MODE_GAS, 1'b0, 12'd1600));
    send_item(item_of(MODE_SPARE, 1'b1, 12'd4095));
    send_item(item_of(MODE_SPARE, 1'b0, 12'd0));
    for (int k = 0; k < 12; k++) send_item(item_of(MODE_TICK, k[0], ADC_W'(k)));
    send_item(item_of(MODE_GAS, 1'b0, 12'd100));

    // Random phases, one register set each
    for (int s = 0; s < NUM_SETS; s++) begin
      drain();
      load_registers(cfg_plan[s]);
      steady = (s == STEADY_SET);
      if (s == PRESSURE_SET) hold_request = 1'b1;
      repeat (set_items[s]) begin
        make_item(it);
        send_item(it);
      end
    end

    drain();
    if (sb.pending_results.size() != 0) begin
      sb.report($sformatf("%0d expected results never arrived", sb.pending_results.size()));
    end
    $display("Covered %0d items over reset defaults and %0d register sets; %0d results checked.",
             sb.items_taken, NUM_SETS, sb.results_checked);
    $display("Echo timing closed %0d averaged rounds; motor enabled in %0d results.",
             sb.rounds_done, sb.motor_on_count);
    if (sb.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d failures in total", sb.failures);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> ultrasonic_range_safety_interlock_top.f
design/urs_pkg.sv
design/urs_ranger.sv
design/ultrasonic_range_safety_interlock_top.sv
tb/tb_ultrasonic_range_safety_interlock_top.sv
